>>> hdl/dbaa_pkg.sv
// Shared types and constants for the doubling arena allocator.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package dbaa_pkg;

    localparam int NUM_REGIONS = 16;

    localparam int BASE_W   = 17;
    localparam int AMOUNT_W = 32;
    localparam int FILL_W   = 32;
    localparam int REGION_W = 4;
    localparam int OFFSET_W = 31;
    localparam int COUNT_W  = 5;

    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(256);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [AMOUNT_W-1:0] amount;
    } t_req;

    typedef struct packed {
        logic                granted;
        logic [REGION_W-1:0] region_index;
        logic [OFFSET_W-1:0] block_offset;
        logic [COUNT_W-1:0]  regions_open;
    } t_rsp;

    // controller -> cell
    typedef struct packed {
        logic clear;   // free all: drop the fill
        logic open;    // region opens now: fill restarts at zero
        logic inject;  // scan starts at this cell
    } t_cell_ctl;

    // cell -> controller / lower neighbor
    typedef struct packed {
        logic              pass;  // token moves to the next lower cell
        logic              hit;   // this cell grants the block
        logic              stop;  // capacity below amount: scan ends
        logic [FILL_W-1:0] fill;
    } t_cell_sts;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

`default_nettype wire

>>> hdl/dbaa_cell.sv
// One region cell of the allocator chain: holds the fill of one region.
// Depends on dbaa_pkg.
`default_nettype none

module dbaa_cell import dbaa_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [REGION_W-1:0] i_idx,
    input  wire logic [BASE_W-1:0]   i_base_size,
    input  wire logic [AMOUNT_W-1:0] i_amount,
    input  wire t_cell_ctl           i_ctl,
    input  wire logic                i_tok,
    output t_cell_sts                o_sts
);

    logic              r_tok;
    logic              n_tok;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [FILL_W-1:0] cap;
    logic              cap_ok;
    logic              room_ok;

    // capacity of region idx: base shifted left by idx, always fits 32 bits
    assign cap     = FILL_W'(i_base_size) << i_idx;
    assign cap_ok  = cap >= i_amount;
    assign room_ok = (r_fill <= cap) && ((cap - r_fill) >= i_amount);

    always_comb begin
        o_sts.pass = r_tok && cap_ok && !room_ok;
        o_sts.hit  = r_tok && cap_ok && room_ok;
        o_sts.stop = r_tok && !cap_ok;
        o_sts.fill = r_fill;

        n_tok  = i_ctl.inject || i_tok;
        n_fill = r_fill;
        if (i_ctl.clear || i_ctl.open) begin
            n_fill = '0;
        end else if (o_sts.hit) begin
            n_fill = r_fill + i_amount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_fill <= '0;
        end else begin
            r_tok  <= n_tok;
            r_fill <= n_fill;
        end
    end

endmodule

`default_nettype wire

>>> hdl/doubling_arena_allocator_unit.sv
// Top level of the doubling arena allocator: controller plus the row of
// region cells. Depends on dbaa_pkg and dbaa_cell.
//
// Usage:
//   Command channel: drive i_req (cmd, amount) with start high; the beat is
//   taken at a clock edge where start is high and busy is low.
//   Result channel: o_valid pulses for exactly one cycle with o_rsp; the
//   receiver cannot stall, so it must take the beat in that cycle.
//   Configuration: i_cfg_we writes i_cfg_data into base_size at the next
//   edge; write it only while busy is low and no result is pending.
//
// Timing:
//   Free all: the result shows in the cycle after the accept.
//   Allocate: a search token walks down the cell row from the newest open
//   region, one cell per cycle, until a cell grants, finds its capacity
//   below the amount or passes cell 0. A miss opens the next region, which
//   the token enters in the next cycle; once all regions are open, a miss
//   gives a failed result. busy falls in the cycle the result shows, so the
//   next command may be taken in that same cycle.
//
// Reset: all regions closed, all fills zero, base_size back to 256.
`default_nettype none

module doubling_arena_allocator_unit import dbaa_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire t_req              i_req,
    output logic                   o_valid,
    output t_rsp                   o_rsp,
    input  wire logic              i_cfg_we,
    input  wire logic [BASE_W-1:0] i_cfg_data
);

    t_state               r_state;
    t_state               n_state;
    logic [COUNT_W-1:0]   r_open_count;
    logic [COUNT_W-1:0]   n_open_count;
    logic [AMOUNT_W-1:0]  r_amount;
    logic [AMOUNT_W-1:0]  n_amount;
    logic [BASE_W-1:0]    r_base_size;
    logic                 r_valid;
    logic                 n_valid;
    t_rsp                 r_rsp;
    t_rsp                 n_rsp;

    t_cell_ctl            cell_ctl [NUM_REGIONS];
    t_cell_sts            cell_sts [NUM_REGIONS];
    logic [NUM_REGIONS-1:0] tok_in;
    logic [NUM_REGIONS-1:0] hit_vec;
    logic [NUM_REGIONS-1:0] stop_vec;
    logic [NUM_REGIONS-1:0] pass_vec;

    logic                 accept;
    logic                 clear_all;
    logic                 open_en;
    logic                 inject_en;
    logic [REGION_W-1:0]  open_pos;
    logic [REGION_W-1:0]  inject_pos;
    logic                 any_hit;
    logic                 scan_end;
    logic [REGION_W-1:0]  hit_idx;
    logic [FILL_W-1:0]    hit_fill;

    assign accept  = start && !busy;
    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // Cell row: the token hands down from cell k+1 to cell k each cycle.
    genvar g;
    generate
        for (g = 0; g < NUM_REGIONS; g++) begin : g_cell
            if (g == NUM_REGIONS - 1) begin : g_top
                assign tok_in[g] = 1'b0;
            end else begin : g_mid
                assign tok_in[g] = cell_sts[g+1].pass;
            end

            assign cell_ctl[g].clear  = clear_all;
            assign cell_ctl[g].open   = open_en && (open_pos == REGION_W'(g));
            assign cell_ctl[g].inject = inject_en && (inject_pos == REGION_W'(g));

            assign hit_vec[g]  = cell_sts[g].hit;
            assign stop_vec[g] = cell_sts[g].stop;
            assign pass_vec[g] = cell_sts[g].pass;

            dbaa_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_idx       (REGION_W'(g)),
                .i_base_size (r_base_size),
                .i_amount    (r_amount),
                .i_ctl       (cell_ctl[g]),
                .i_tok       (tok_in[g]),
                .o_sts       (cell_sts[g])
            );
        end
    endgenerate

    // Only one cell holds the token, so an OR over masked cells selects it.
    always_comb begin
        hit_idx  = '0;
        hit_fill = '0;
        for (int k = 0; k < NUM_REGIONS; k++) begin
            if (hit_vec[k]) begin
                hit_idx  = hit_idx | REGION_W'(k);
                hit_fill = hit_fill | cell_sts[k].fill;
            end
        end
    end

    assign any_hit  = |hit_vec;
    // token fell off cell 0 or met a region too small: nothing open fits
    assign scan_end = (|stop_vec) || pass_vec[0];

    always_comb begin
        n_state      = r_state;
        n_open_count = r_open_count;
        n_amount     = r_amount;
        n_valid      = 1'b0;
        n_rsp        = r_rsp;
        clear_all    = 1'b0;
        open_en      = 1'b0;
        inject_en    = 1'b0;
        open_pos     = r_open_count[REGION_W-1:0];
        inject_pos   = r_open_count[REGION_W-1:0];

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req.cmd == CMD_FREE) begin
                        // drop every region and report at once
                        clear_all          = 1'b1;
                        n_open_count       = '0;
                        n_valid            = 1'b1;
                        n_rsp.granted      = 1'b0;
                        n_rsp.region_index = '0;
                        n_rsp.block_offset = '0;
                        n_rsp.regions_open = '0;
                    end else begin
                        n_amount = i_req.amount;
                        n_state  = ST_SCAN;
                        if (r_open_count == '0) begin
                            // nothing open: open region 0 and start there
                            open_en      = 1'b1;
                            inject_en    = 1'b1;
                            n_open_count = r_open_count + COUNT_W'(1);
                        end else begin
                            // start at the newest open region
                            inject_en  = 1'b1;
                            inject_pos = REGION_W'(r_open_count - COUNT_W'(1));
                        end
                    end
                end
            end

            ST_SCAN: begin
                if (any_hit) begin
                    n_state            = ST_IDLE;
                    n_valid            = 1'b1;
                    n_rsp.granted      = 1'b1;
                    n_rsp.region_index = hit_idx;
                    n_rsp.block_offset = hit_fill[OFFSET_W-1:0];
                    n_rsp.regions_open = r_open_count;
                end else if (scan_end) begin
                    if (r_open_count < COUNT_W'(NUM_REGIONS)) begin
                        // open the next region and try it right away
                        open_en      = 1'b1;
                        inject_en    = 1'b1;
                        n_open_count = r_open_count + COUNT_W'(1);
                    end else begin
                        n_state            = ST_IDLE;
                        n_valid            = 1'b1;
                        n_rsp.granted      = 1'b0;
                        n_rsp.region_index = '0;
                        n_rsp.block_offset = '0;
                        n_rsp.regions_open = r_open_count;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_open_count <= '0;
            r_valid      <= 1'b0;
            r_base_size  <= BASE_RESET;
        end else begin
            r_state      <= n_state;
            r_open_count <= n_open_count;
            r_valid      <= n_valid;
            if (i_cfg_we) begin
                r_base_size <= i_cfg_data;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_amount <= n_amount;
        r_rsp    <= n_rsp;
    end

    // at most one cell acts on the token in any cycle
    a_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({hit_vec, stop_vec, pass_vec}))
        else $error("more than one cell holds the search token");

    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open_count <= COUNT_W'(NUM_REGIONS))
        else $error("open region count exceeds region total");

    a_grant_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.granted |->
            COUNT_W'(o_rsp.region_index) < o_rsp.regions_open)
        else $error("granted region is not open");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rsp.granted |->
            (o_rsp.region_index == '0) && (o_rsp.block_offset == '0))
        else $error("failed result carries region or offset");

    a_token_only_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !(any_hit || scan_end))
        else $error("cell active while controller is idle");

endmodule

`default_nettype wire
